FILE: sv/ntm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntm_pkg
// Types and codes shared by the nearest timestamp matcher, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package ntm_pkg;

   localparam int STAMP_W  = 64;
   localparam int SLOT_W   = 8;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 2'd0,
      OP_LOAD  = 2'd1,
      OP_MATCH = 2'd2
   } opcode_type;

   localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd2;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_SCAN,
      S_DRAIN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic               valid;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage
`default_nettype wire

FILE: sv/ntm_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntm channel interfaces
// Valid/ready channels for requests, responses and the tolerance register.
// ----------------------------------------------------------------------------
interface ntm_req_if;
   logic                   valid;
   logic                   ready;
   logic [ntm_pkg::OP_W-1:0]    opcode;
   logic [ntm_pkg::STAMP_W-1:0] stamp;

   modport source (output valid, output opcode, output stamp, input ready);
   modport sink   (input valid, input opcode, input stamp, output ready);
endinterface

interface ntm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ntm_pkg::STATUS_W-1:0] status;
   logic                         matched;
   logic [ntm_pkg::STAMP_W-1:0]  partner_stamp;
   logic [ntm_pkg::SLOT_W-1:0]   partner_slot;

   modport source (output valid, output status, output matched,
                   output partner_stamp, output partner_slot, input ready);
   modport sink   (input valid, input status, input matched,
                   input partner_stamp, input partner_slot, output ready);
endinterface

interface ntm_csr_if;
   logic                        valid;
   logic                        ready;
   logic [ntm_pkg::STAMP_W-1:0] tolerance_ns;

   modport source (output valid, output tolerance_ns, input ready);
   modport sink   (input valid, input tolerance_ns, output ready);
endinterface
`default_nettype wire

FILE: sv/nearest_timestamp_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_timestamp_matcher_top
// Table of second-stream timestamps matched against first-stream timestamps.
// ----------------------------------------------------------------------------
// Usage:
//   req carries an opcode (clear, load, match) and a 64-bit timestamp; every
//   accepted request produces exactly one transfer on rsp. csr writes the
//   match tolerance and is always ready; write it only while the block idles.
//   Load and match walk the whole table through one read port of the entry
//   memory, one slot per cycle, into a two-stage distance/compare pipeline.
//   A load or match passes through scan, drain and finish before its result
//   is registered, a clear through clear and finish, an unused opcode through
//   finish alone; req is ready again in the same cycle that the result first
//   shows on rsp. The next request is accepted while a result still waits
//   in the output register.
//   After reset the block sweeps every memory slot to clear its valid mark,
//   with req not ready; csr writes are taken meanwhile.
//   When rsp is stalled the finished result holds in its register, and a
//   following request waits at its final step until the output frees up.
// ----------------------------------------------------------------------------
module nearest_timestamp_matcher_top
   import ntm_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   ntm_csr_if.sink    csr,
   ntm_req_if.sink    req,
   ntm_rsp_if.source  rsp
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   entry_type mem [TABLE_DEPTH];

   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   addr_ff, addr_in;
   opcode_type         op_ff;
   logic [STAMP_W-1:0] key_ff;
   logic [STAMP_W-1:0] tolerance_ff;

   // Read stage.
   logic               s1_vld_ff;
   logic [IDX_W-1:0]   s1_idx_ff;
   entry_type          rd_data_ff;

   // Distance stage.
   logic               s2_vld_ff;
   logic [IDX_W-1:0]   s2_idx_ff;
   logic               s2_live_ff;
   logic [STAMP_W-1:0] s2_dist_ff;
   logic               s2_below_ff;
   logic               s2_eq_ff;
   logic [STAMP_W-1:0] s2_stamp_ff;

   // Running best and load scan results.
   logic               have_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [STAMP_W-1:0] best_dist_ff;
   logic               best_below_ff;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic               dup_ff;
   logic               free_ff;
   logic [IDX_W-1:0]   free_idx_ff;

   // Output register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_matched_ff;
   logic [STAMP_W-1:0]  rsp_stamp_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   logic                accept;
   logic                out_free;
   logic                rsp_load;
   logic                hit;
   logic                better;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;
   logic [STATUS_W-1:0] res_status;
   logic                res_matched;
   logic [STAMP_W-1:0]  res_stamp;
   logic [SLOT_W-1:0]   res_slot;
   logic                borrow;
   logic [STAMP_W-1:0]  diff_up;
   logic [STAMP_W-1:0]  diff_down;

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (addr_ff == LAST_IDX) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               case (opcode_type'(req.opcode))
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_LOAD:  state_in = S_SCAN;
                  OP_MATCH: state_in = S_SCAN;
                  default:  state_in = S_FINISH;
               endcase
            end
         end
         S_CLEAR: begin
            if (addr_ff == LAST_IDX) state_in = S_FINISH;
         end
         S_SCAN: begin
            if (addr_ff == LAST_IDX) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // The last compare has landed once both stages are empty.
            if (!s1_vld_ff && !s2_vld_ff) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (state_ff == S_INIT || state_ff == S_CLEAR || state_ff == S_SCAN) begin
         addr_in = (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
      end else begin
         addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // ------------------------------------------------------------------
   // Control outputs, result and memory write
   // ------------------------------------------------------------------
   assign hit = have_ff && (best_dist_ff <= tolerance_ff);

   always_comb begin
      req.ready = (state_ff == S_IDLE);
      csr.ready = 1'b1;
      accept    = req.valid && (state_ff == S_IDLE);
      out_free  = !rsp_valid_ff || rsp.ready;
      rsp_load  = (state_ff == S_FINISH) && out_free;

      res_status  = STATUS_DONE;
      res_matched = 1'b0;
      res_stamp   = '0;
      res_slot    = '0;
      case (op_ff)
         OP_LOAD: begin
            if (dup_ff)        res_status = STATUS_DUP;
            else if (!free_ff) res_status = STATUS_FULL;
         end
         OP_MATCH: begin
            if (hit) begin
               res_matched = 1'b1;
               res_stamp   = best_stamp_ff;
               res_slot    = SLOT_W'(best_idx_ff);
            end
         end
         default: ;
      endcase

      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (state_ff == S_INIT || state_ff == S_CLEAR) begin
         wr_en = 1'b1;
      end else if (rsp_load) begin
         case (op_ff)
            OP_LOAD: begin
               if (!dup_ff && free_ff) begin
                  wr_en         = 1'b1;
                  wr_addr       = free_idx_ff;
                  wr_data.valid = 1'b1;
                  wr_data.stamp = key_ff;
               end
            end
            OP_MATCH: begin
               // Retire the partner so it matches only once.
               if (hit) begin
                  wr_en         = 1'b1;
                  wr_addr       = best_idx_ff;
                  wr_data.valid = 1'b0;
                  wr_data.stamp = best_stamp_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[addr_ff];
   end

   // ------------------------------------------------------------------
   // Request capture and tolerance register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= '0;
      end else if (csr.valid) begin
         tolerance_ff <= csr.tolerance_ns;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= opcode_type'(req.opcode);
         key_ff <= req.stamp;
      end
   end

   // ------------------------------------------------------------------
   // Scan pipeline: read, distance, compare
   // ------------------------------------------------------------------
   assign {borrow, diff_up} = {1'b0, rd_data_ff.stamp} - {1'b0, key_ff};
   assign diff_down         = key_ff - rd_data_ff.stamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= (state_ff == S_SCAN);
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff   <= addr_ff;
      s2_idx_ff   <= s1_idx_ff;
      s2_live_ff  <= rd_data_ff.valid;
      s2_stamp_ff <= rd_data_ff.stamp;
      s2_dist_ff  <= borrow ? diff_down : diff_up;
      s2_below_ff <= borrow;
      s2_eq_ff    <= (rd_data_ff.stamp == key_ff);
   end

   // Equal distances come from one entry below and one above the key, so the
   // entry below (the smaller timestamp) wins the tie.
   assign better = !have_ff || (s2_dist_ff < best_dist_ff) ||
                   ((s2_dist_ff == best_dist_ff) && s2_below_ff && !best_below_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         dup_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (accept) begin
         have_ff <= 1'b0;
         dup_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (s2_vld_ff) begin
         if (s2_live_ff) begin
            if (s2_eq_ff) dup_ff <= 1'b1;
            if (better)   have_ff <= 1'b1;
         end else if (!free_ff) begin
            free_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_vld_ff && s2_live_ff && better) begin
         best_idx_ff   <= s2_idx_ff;
         best_dist_ff  <= s2_dist_ff;
         best_below_ff <= s2_below_ff;
         best_stamp_ff <= s2_stamp_ff;
      end
      if (s2_vld_ff && !s2_live_ff && !free_ff) begin
         free_idx_ff <= s2_idx_ff;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff  <= res_status;
         rsp_matched_ff <= res_matched;
         rsp_stamp_ff   <= res_stamp;
         rsp_slot_ff    <= res_slot;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.matched       = rsp_matched_ff;
   assign rsp.partner_stamp = rsp_stamp_ff;
   assign rsp.partner_slot  = rsp_slot_ff;

endmodule
`default_nettype wire

FILE: sv/ntm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ntm_checker
// Port-level checks on the nearest timestamp matcher, bound to its top level.
// ----------------------------------------------------------------------------
module ntm_checker
   import ntm_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                rsp_matched,
   input logic [STAMP_W-1:0]  rsp_partner_stamp,
   input logic [SLOT_W-1:0]   rsp_partner_slot
);

   // A stalled result must not change until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_matched) && $stable(rsp_partner_stamp) && $stable(rsp_partner_slot))
      else $error("ntm: stalled response changed");

   // The table is being wiped right after reset, so no request and no result.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ntm: activity right after reset");

   // One request at a time: acceptance closes the request side.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ntm: request side stayed open after a transfer");

   // An unmatched result carries no partner, and a match is never a load error.
   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_matched ? (rsp_status == STATUS_DONE)
                                 : (rsp_partner_stamp == '0 && rsp_partner_slot == '0)))
      else $error("ntm: inconsistent response fields");

endmodule

bind nearest_timestamp_matcher_top ntm_checker u_ntm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req.valid),
   .req_ready         (req.ready),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_status        (rsp.status),
   .rsp_matched       (rsp.matched),
   .rsp_partner_stamp (rsp.partner_stamp),
   .rsp_partner_slot  (rsp.partner_slot)
);
`default_nettype wire

FILE: dv/nearest_timestamp_matcher_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_timestamp_matcher_top_tb
// Self-checking bench for the timestamp matcher. A short table of directed
// requests covers the field extremes, every opcode, ties, duplicate loads and
// distances near the 64-bit limits. Random load/match sequences follow, with
// one episode that fills the table to overflow. Every response transfer is
// compared field by field with a typed row's result or a shadow of the table.
// ----------------------------------------------------------------------------
module nearest_timestamp_matcher_top_tb;
   import ntm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH  = 256;
   localparam int RANDOM_ITEMS = 950;
   localparam int STALL_LIMIT  = 8 * TABLE_DEPTH + 256;

   localparam logic [OP_W-1:0]    OP_UNUSED = 2'd3;
   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                matched;
      logic [STAMP_W-1:0]  partner_stamp;
      logic [SLOT_W-1:0]   partner_slot;
   } outcome_type;

   typedef enum bit {ROW_REQUEST, ROW_TOLERANCE} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [OP_W-1:0]    op;
      logic [STAMP_W-1:0] value;
      bit                 typed;
      outcome_type        want;
   } vector_type;

   localparam outcome_type PLAIN_DONE = '{STATUS_DONE, 1'b0, 64'd0, 8'd0};

   localparam int N_ROWS = 27;

   // Tolerance rows carry the new register value in the value column.
   vector_type directed_rows[N_ROWS] = '{
      '{ROW_REQUEST,   OP_MATCH,  64'd0,     1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_UNUSED, STAMP_MAX, 1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_LOAD,   64'd0,     1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_LOAD,   STAMP_MAX, 1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_LOAD,   64'd0,     1'b1, '{STATUS_DUP, 1'b0, 64'd0, 8'd0}},
      '{ROW_REQUEST,   OP_LOAD,   64'd1000,  1'b0, PLAIN_DONE},
      '{ROW_REQUEST,   OP_LOAD,   64'd1010,  1'b0, PLAIN_DONE},
      '{ROW_REQUEST,   OP_MATCH,  64'd1005,  1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_MATCH,  64'd1010,  1'b1, '{STATUS_DONE, 1'b1, 64'd1010, 8'd3}},
      '{ROW_REQUEST,   OP_MATCH,  64'd0,     1'b1, '{STATUS_DONE, 1'b1, 64'd0, 8'd0}},
      '{ROW_REQUEST,   OP_MATCH,  64'd0,     1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_CLEAR,  STAMP_MAX, 1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_MATCH,  64'd1000,  1'b1, PLAIN_DONE},
      '{ROW_TOLERANCE, OP_CLEAR,  64'd10,    1'b0, PLAIN_DONE},
      '{ROW_REQUEST,   OP_LOAD,   64'd1000,  1'b0, PLAIN_DONE},
      '{ROW_REQUEST,   OP_LOAD,   64'd1020,  1'b0, PLAIN_DONE},
      '{ROW_REQUEST,   OP_LOAD,   64'd3,     1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_MATCH,  64'd1010,  1'b1, '{STATUS_DONE, 1'b1, 64'd1000, 8'd0}},
      '{ROW_REQUEST,   OP_MATCH,  64'd1010,  1'b1, '{STATUS_DONE, 1'b1, 64'd1020, 8'd1}},
      '{ROW_REQUEST,   OP_MATCH,  STAMP_MAX, 1'b1, PLAIN_DONE},
      '{ROW_TOLERANCE, OP_CLEAR,  STAMP_MAX, 1'b0, PLAIN_DONE},
      '{ROW_REQUEST,   OP_LOAD,   64'hFFFF_FFFF_FFFF_FFF0, 1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_MATCH,  STAMP_MAX, 1'b1,
        '{STATUS_DONE, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0, 8'd0}},
      '{ROW_REQUEST,   OP_MATCH,  STAMP_MAX, 1'b1, '{STATUS_DONE, 1'b1, 64'd3, 8'd2}},
      '{ROW_REQUEST,   OP_LOAD,   64'd0,     1'b1, PLAIN_DONE},
      '{ROW_REQUEST,   OP_MATCH,  STAMP_MAX, 1'b1, '{STATUS_DONE, 1'b1, 64'd0, 8'd0}},
      '{ROW_REQUEST,   OP_MATCH,  64'd42,    1'b1, PLAIN_DONE}
   };

   logic clock;
   logic reset;

   ntm_csr_if csr_ch ();
   ntm_req_if req_ch ();
   ntm_rsp_if rsp_ch ();

   nearest_timestamp_matcher_top #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr  (csr_ch),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   // Shadow of the matching table and of the tolerance register.
   logic [STAMP_W-1:0] shadow_stamp[TABLE_DEPTH];
   bit                 shadow_valid[TABLE_DEPTH];
   logic [STAMP_W-1:0] tolerance_now;

   outcome_type pending_outcomes[$];
   int          mismatch_count;
   int          counted_items;
   int          sender_idle_pct;
   int          rsp_idle_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic outcome_type apply_request(input logic [OP_W-1:0] op,
                                                 input logic [STAMP_W-1:0] stamp);
      outcome_type        res;
      bit                 dup;
      int                 free_slot;
      int                 best;
      logic [STAMP_W-1:0] distance;
      logic [STAMP_W-1:0] best_dist;
      res       = PLAIN_DONE;
      dup       = 1'b0;
      free_slot = -1;
      best      = -1;
      best_dist = '0;
      case (op)
         OP_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;
         end
         OP_LOAD: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (shadow_valid[i]) begin
                  if (shadow_stamp[i] == stamp) dup = 1'b1;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            // A duplicate is reported even when the table is full.
            if (dup) begin
               res.status = STATUS_DUP;
            end else if (free_slot < 0) begin
               res.status = STATUS_FULL;
            end else begin
               shadow_stamp[free_slot] = stamp;
               shadow_valid[free_slot] = 1'b1;
            end
         end
         OP_MATCH: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (shadow_valid[i]) begin
                  distance = (shadow_stamp[i] > stamp) ? shadow_stamp[i] - stamp
                                                       : stamp - shadow_stamp[i];
                  if (best < 0 || distance < best_dist ||
                      (distance == best_dist && shadow_stamp[i] < shadow_stamp[best])) begin
                     best      = i;
                     best_dist = distance;
                  end
               end
            end
            if (best >= 0 && best_dist <= tolerance_now) begin
               res.matched       = 1'b1;
               res.partner_stamp = shadow_stamp[best];
               res.partner_slot  = SLOT_W'(best);
               shadow_valid[best] = 1'b0;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [STAMP_W-1:0] random_stamp();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [STAMP_W-1:0] pick_base();
      case ($urandom_range(0, 2))
         0:       return 64'($urandom_range(0, 1000));
         1:       return random_stamp();
         default: return STAMP_MAX - 64'($urandom_range(0, 1000));
      endcase
   endfunction

   // Presents one request and holds it until the transfer; the shadow table
   // is updated at the edge where the request is taken.
   task automatic submit_request(input logic [OP_W-1:0] op,
                                 input logic [STAMP_W-1:0] stamp,
                                 input bit typed, input outcome_type want);
      int          gap;
      outcome_type predicted;
      gap = 0;
      if ($urandom_range(0, 99) < sender_idle_pct) gap = $urandom_range(1, TABLE_DEPTH + 8);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.opcode <= op;
      req_ch.stamp  <= stamp;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = apply_request(op, stamp);
      pending_outcomes.push_back(typed ? want : predicted);
      if (op != OP_UNUSED) counted_items++;
   endtask

   task automatic issue(input logic [OP_W-1:0] op, input logic [STAMP_W-1:0] stamp);
      submit_request(op, stamp, 1'b0, PLAIN_DONE);
   endtask

   // The register is only written once every outstanding result is back.
   task automatic write_tolerance(input logic [STAMP_W-1:0] value);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.tolerance_ns <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid  <= 1'b0;
      tolerance_now = value;
   endtask

   task automatic maybe_retune();
      if ($urandom_range(0, 4) == 0) begin
         case ($urandom_range(0, 4))
            0:       write_tolerance('0);
            1:       write_tolerance(64'($urandom_range(0, 40)));
            2:       write_tolerance(64'($urandom_range(0, 1000)));
            3:       write_tolerance(random_stamp());
            default: write_tolerance(STAMP_MAX);
         endcase
      end
   endtask

   // Loads an ascending run of second-stream stamps, then matches first-stream
   // stamps that wander around them in ascending order.
   task automatic run_tracking_episode();
      logic [STAMP_W-1:0] cursor;
      logic [STAMP_W-1:0] loaded[$];
      int                 jit;
      cursor = pick_base();
      if ($urandom_range(0, 3) != 0) issue(OP_CLEAR, random_stamp());
      repeat ($urandom_range(1, 12)) begin
         cursor = cursor + 64'($urandom_range(0, 60));
         loaded.push_back(cursor);
         issue(OP_LOAD, cursor);
      end
      foreach (loaded[k]) begin
         jit = $urandom_range(0, 60) - 30;
         issue(OP_MATCH, loaded[k] + {{32{jit[31]}}, jit});
         if ($urandom_range(0, 4) == 0) begin
            cursor = cursor + 64'($urandom_range(1, 60));
            issue(OP_LOAD, cursor);
         end
      end
   endtask

   task automatic run_noise_episode();
      logic [STAMP_W-1:0] anchor;
      anchor = pick_base();
      repeat ($urandom_range(3, 10)) begin
         if ($urandom_range(0, 1) == 0)
            issue(2'($urandom_range(0, 3)), random_stamp());
         else
            issue(2'($urandom_range(0, 3)), anchor + 64'($urandom_range(0, 100)));
      end
   endtask

   // Fills every slot, overflows, then frees a few slots and refills them.
   task automatic run_fill_episode();
      logic [STAMP_W-1:0] loaded[$];
      logic [STAMP_W-1:0] s;
      issue(OP_CLEAR, random_stamp());
      repeat (TABLE_DEPTH + 2) begin
         s = random_stamp();
         loaded.push_back(s);
         issue(OP_LOAD, s);
      end
      issue(OP_LOAD, loaded[$urandom_range(0, TABLE_DEPTH - 1)]);
      repeat (4) issue(OP_MATCH, loaded[$urandom_range(0, TABLE_DEPTH - 1)]);
      repeat (5) issue(OP_LOAD, random_stamp());
   endtask

   initial begin
      int  target;
      bit  fill_done;
      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.opcode       <= OP_CLEAR;
      req_ch.stamp        <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.tolerance_ns <= '0;
      tolerance_now   = '0;
      mismatch_count  = 0;
      counted_items   = 0;
      sender_idle_pct = 0;
      rsp_idle_pct    = 0;
      fill_done       = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         shadow_stamp[i] = '0;
         shadow_valid[i] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_TOLERANCE)
            write_tolerance(directed_rows[r].value);
         else
            submit_request(directed_rows[r].op, directed_rows[r].value,
                           directed_rows[r].typed, directed_rows[r].want);
      end

      target = counted_items + RANDOM_ITEMS;
      while (counted_items < target) begin
         if (target - counted_items > 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct = 25;
            rsp_idle_pct    = 68;
         end else if (target - counted_items > RANDOM_ITEMS / 3) begin
            sender_idle_pct = 68;
            rsp_idle_pct    = 25;
         end else begin
            sender_idle_pct = 0;
            rsp_idle_pct    = 0;
         end
         maybe_retune();
         if (!fill_done && target - counted_items < 2 * RANDOM_ITEMS / 3) begin
            run_fill_episode();
            fill_done = 1'b1;
         end else if ($urandom_range(0, 3) == 0) begin
            run_noise_episode();
         end else begin
            run_tracking_episode();
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic void compare_field(input string field,
                                         input logic [STAMP_W-1:0] want,
                                         input logic [STAMP_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: result transfer with nothing outstanding, expected none, actual %0h %0b %0h %0h",
                     $time, rsp_ch.status, rsp_ch.matched, rsp_ch.partner_stamp,
                     rsp_ch.partner_slot);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            compare_field("status", 64'(want.status), 64'(rsp_ch.status));
            compare_field("matched", 64'(want.matched), 64'(rsp_ch.matched));
            compare_field("partner_stamp", want.partner_stamp, rsp_ch.partner_stamp);
            compare_field("partner_slot", 64'(want.partner_slot), 64'(rsp_ch.partner_slot));
         end
      end
   end

   // Ends a hung run: no transfer on any channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
             (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire
